/* rtl/sws_pkg.sv */
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the sliding window lane search block.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int MAX_PIXELS_DEF  = 65536;
   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int WINDOWS_DEF     = 20;

   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 17;
   localparam int DIV_CNT_W = 5;

   localparam logic [16:0] CNT_MAX = 17'h1FFFF;
   localparam logic [26:0] SUM_MAX = 27'h7FFFFFF;

   localparam logic [10:0] ROWS_RESET   = 11'd720;
   localparam logic [10:0] COLS_RESET   = 11'd1024;
   localparam logic [7:0]  MARGIN_RESET = 8'd60;
   localparam logic [15:0] MINPIX_RESET = 16'd50;
   localparam logic [8:0]  LSS_RESET    = 9'd50;

   localparam logic [2:0] REG_IMAGE_ROWS   = 3'd0;
   localparam logic [2:0] REG_IMAGE_COLS   = 3'd1;
   localparam logic [2:0] REG_SEARCH_MARGIN = 3'd2;
   localparam logic [2:0] REG_MIN_PIXELS   = 3'd3;
   localparam logic [2:0] REG_LEFT_START   = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HRD,
      ST_HWR,
      ST_PEAK,
      ST_PEAK_END,
      ST_BAND,
      ST_BDIV,
      ST_SCAN,
      ST_EMIT,
      ST_LDIV,
      ST_LWAIT,
      ST_RDIV,
      ST_RWAIT,
      ST_NEXT
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

/* rtl/sliding_window_lane_search_top.sv */
// ----------------------------------------------------------------------------
// sliding_window_lane_search_top
// Lane pixel search: stores the pixels of a frame, builds a column histogram,
// finds the two base peaks and walks the sliding windows band by band.
//
//   channel | direction | beat contents
//   req_    | in        | pixel_x, pixel_y, frame_end
//   rsp_    | out       | window_index, centers, counts, last_window
//   csr_    | in        | register index, write data
//
// Each pixel passes the idle, histogram read and histogram write states of the
// read-modify-write of the histogram memory. A frame end adds a peak search
// over all MAX_COLUMNS bins (which also clears the histogram), then per band
// the ST_BAND and ST_BDIV states to find the band limits, a pass over the
// pixel store, the emit and step states and the recentre divides in the shared
// divider. After reset the histogram is cleared before the first pixel is
// taken. A stalled result holds the sequencer; loading resumes while the last
// result still waits.
// ----------------------------------------------------------------------------
module sliding_window_lane_search_top #(
   parameter int MAX_PIXELS  = sws_pkg::MAX_PIXELS_DEF,
   parameter int MAX_COLUMNS = sws_pkg::MAX_COLUMNS_DEF,
   parameter int WINDOWS     = sws_pkg::WINDOWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_pixel_x,
   input  logic [9:0]  req_pixel_y,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_window_index,
   output logic [9:0]  rsp_left_center,
   output logic [9:0]  rsp_right_center,
   output logic [16:0] rsp_left_count,
   output logic [16:0] rsp_right_count,
   output logic        rsp_last_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int PW = $clog2(MAX_PIXELS);
   localparam int COL_LIM = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
   localparam int BAND_SHIFT = 21;
   localparam logic [21:0] BAND_RECIP = 22'(((1 << BAND_SHIFT) + WINDOWS - 1) / WINDOWS);

   // Configuration registers.
   logic [10:0] rows_cfg_ff, cols_cfg_ff;
   logic [7:0]  margin_ff;
   logic [15:0] minpix_ff;
   logic [8:0]  lss_ff;

   sws_pkg::state_type state_ff, state_in;
   logic [CW:0]   col_ff, col_in;
   logic          pv_ff, pv_in;
   logic [CW-1:0] pcol_ff, pcol_in;
   logic [16:0]   lbest_ff, lbest_in, rbest_ff, rbest_in;
   logic          lany_ff, lany_in, rany_ff, rany_in;
   logic [9:0]    lbase_ff, lbase_in, rbase_ff, rbase_in;
   logic [9:0]    px_ff, px_in, py_ff, py_in;
   logic          pend_ff, pend_in;
   logic [PW:0]   total_ff, total_in, idx_ff, idx_in;
   logic          sv_ff, sv_in;
   logic [4:0]    band_ff, band_in;
   logic [10:0]   ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic [15:0]   prod_ff, prod_in;
   logic [16:0]   lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   logic [26:0]   lsum_ff, lsum_in, rsum_ff, rsum_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rsp_index_ff, rsp_index_in;
   logic [9:0]    rsp_lc_ff, rsp_lc_in, rsp_rc_ff, rsp_rc_in;
   logic [16:0]   rsp_lcnt_ff, rsp_lcnt_in, rsp_rcnt_ff, rsp_rcnt_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          h_we;
   logic [CW-1:0] h_waddr, h_raddr;
   logic [16:0]   h_wdata, h_rdata;
   logic          s_we;
   logic [PW-1:0] s_waddr, s_raddr;
   logic [19:0]   s_wdata, s_rdata;

   sws_pkg::div_req_type div_req;
   sws_pkg::div_rsp_type div_rsp;

   logic [10:0] rows, cols, hi_left;
   logic [9:0]  half, mid;
   logic        in_frame, in_rows;
   logic [15:0] pc;
   logic [9:0]  sx, sy;
   logic [10:0] sx_ext, sy_ext;
   logic [27:0] lsum_add, rsum_add;
   logic [4:0]  kband;
   logic [9:0]  quot_sat;
   logic [37:0] band_prod;

   sws_ram #(.DEPTH(MAX_COLUMNS), .WIDTH(17)) u_hist (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   sws_ram #(.DEPTH(MAX_PIXELS), .WIDTH(20)) u_store (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   sws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Effective frame size after clamping.
   always_comb begin
      rows = rows_cfg_ff;
      if (rows == 11'd0) rows = 11'd1;
      if (rows > 11'd1024) rows = 11'd1024;
      cols = cols_cfg_ff;
      if (cols > 11'(COL_LIM)) cols = 11'(COL_LIM);
      if (cols < 11'd2) cols = 11'd2;
      half    = rows[10:1];
      mid     = cols[10:1];
      hi_left = 11'(lss_ff) + 11'(mid);
      if (hi_left > cols) hi_left = cols;
   end

   assign in_frame = (11'(px_ff) < cols) && (11'(py_ff) < rows);
   assign in_rows  = (py_ff >= half) && (11'(py_ff) < {half, 1'b0});
   assign pc       = 16'(pcol_ff);
   assign sx       = s_rdata[9:0];
   assign sy       = s_rdata[19:10];
   assign sx_ext   = 11'(sx);
   assign sy_ext   = 11'(sy);
   assign lsum_add = {1'b0, lsum_ff} + 28'(sx);
   assign rsum_add = {1'b0, rsum_ff} + 28'(sx);
   assign kband    = 5'(WINDOWS - 1) - band_ff;
   assign quot_sat = (div_rsp.quot > 27'd1023) ? 10'd1023 : div_rsp.quot[9:0];
   // The product stays below 2^15, where the rounded-up reciprocal is exact.
   assign band_prod = {22'd0, prod_ff} * {16'd0, BAND_RECIP};

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      pv_in    = pv_ff;
      pcol_in  = pcol_ff;
      lbest_in = lbest_ff;
      rbest_in = rbest_ff;
      lany_in  = lany_ff;
      rany_in  = rany_ff;
      lbase_in = lbase_ff;
      rbase_in = rbase_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pend_in  = pend_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      sv_in    = sv_ff;
      band_in  = band_ff;
      ylo_in   = ylo_ff;
      yhi_in   = yhi_ff;
      prod_in  = prod_ff;
      lcnt_in  = lcnt_ff;
      rcnt_in  = rcnt_ff;
      lsum_in  = lsum_ff;
      rsum_in  = rsum_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_lc_in    = rsp_lc_ff;
      rsp_rc_in    = rsp_rc_ff;
      rsp_lcnt_in  = rsp_lcnt_ff;
      rsp_rcnt_in  = rsp_rcnt_ff;
      rsp_last_in  = rsp_last_ff;

      h_we    = 1'b0;
      h_waddr = CW'(px_ff);
      h_wdata = h_rdata + 17'd1;
      h_raddr = CW'(px_ff);
      s_we    = 1'b0;
      s_waddr = total_ff[PW-1:0];
      s_wdata = {py_ff, px_ff};
      s_raddr = idx_ff[PW-1:0];

      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;

      req_ready = 1'b0;

      case (state_ff)
         sws_pkg::ST_CLEAR: begin
            h_we    = 1'b1;
            h_waddr = col_ff[CW-1:0];
            h_wdata = '0;
            col_in  = col_ff + 1'b1;
            if (col_ff == (CW+1)'(MAX_COLUMNS - 1)) begin
               col_in   = '0;
               state_in = sws_pkg::ST_IDLE;
            end
         end
         sws_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               pend_in  = req_frame_end;
               state_in = sws_pkg::ST_HRD;
            end
         end
         sws_pkg::ST_HRD: begin
            if (in_frame && (total_ff < (PW+1)'(MAX_PIXELS))) begin
               s_we     = 1'b1;
               total_in = total_ff + 1'b1;
            end
            state_in = sws_pkg::ST_HWR;
         end
         sws_pkg::ST_HWR: begin
            h_we = in_frame && in_rows && (h_rdata != sws_pkg::CNT_MAX);
            if (pend_ff) begin
               col_in   = '0;
               pv_in    = 1'b0;
               lany_in  = 1'b0;
               rany_in  = 1'b0;
               state_in = sws_pkg::ST_PEAK;
            end else begin
               state_in = sws_pkg::ST_IDLE;
            end
         end
         sws_pkg::ST_PEAK: begin
            // Every bin is read once for the peak search and zeroed behind it.
            h_raddr = col_ff[CW-1:0];
            h_waddr = col_ff[CW-1:0];
            h_wdata = '0;
            h_we    = 1'b1;
            if (col_ff != (CW+1)'(MAX_COLUMNS)) begin
               col_in  = col_ff + 1'b1;
               pv_in   = 1'b1;
               pcol_in = col_ff[CW-1:0];
            end else begin
               pv_in = 1'b0;
               if (!pv_ff) state_in = sws_pkg::ST_PEAK_END;
            end
            if (pv_ff) begin
               if (pc >= 16'(lss_ff) && pc < 16'(hi_left) &&
                   (!lany_ff || h_rdata > lbest_ff)) begin
                  lbest_in = h_rdata;
                  lbase_in = 10'(pcol_ff);
                  lany_in  = 1'b1;
               end
               if (pc >= 16'(mid) && pc < 16'({mid, 1'b0}) &&
                   (!rany_ff || h_rdata > rbest_ff)) begin
                  rbest_in = h_rdata;
                  rbase_in = 10'(pcol_ff);
                  rany_in  = 1'b1;
               end
            end
         end
         sws_pkg::ST_PEAK_END: begin
            if (!lany_ff) lbase_in = 10'(lss_ff);
            band_in  = '0;
            yhi_in   = rows;
            state_in = sws_pkg::ST_BAND;
         end
         sws_pkg::ST_BAND: begin
            prod_in  = 16'(rows) * 16'(kband);
            state_in = sws_pkg::ST_BDIV;
         end
         sws_pkg::ST_BDIV: begin
            ylo_in   = band_prod[BAND_SHIFT +: 11];
            idx_in   = '0;
            sv_in    = 1'b0;
            lcnt_in  = '0;
            rcnt_in  = '0;
            lsum_in  = '0;
            rsum_in  = '0;
            state_in = sws_pkg::ST_SCAN;
         end
         sws_pkg::ST_SCAN: begin
            if (idx_ff != total_ff) begin
               idx_in = idx_ff + 1'b1;
               sv_in  = 1'b1;
            end else begin
               sv_in = 1'b0;
               if (!sv_ff) state_in = sws_pkg::ST_EMIT;
            end
            if (sv_ff && sy_ext >= ylo_ff && sy_ext < yhi_ff) begin
               // Lower window edge compared as x + margin >= centre, never negative.
               if (sx_ext + 11'(margin_ff) >= 11'(lbase_ff) &&
                   sx_ext < 11'(lbase_ff) + 11'(margin_ff)) begin
                  if (lcnt_ff != sws_pkg::CNT_MAX) lcnt_in = lcnt_ff + 1'b1;
                  lsum_in = (lsum_add > 28'(sws_pkg::SUM_MAX)) ? sws_pkg::SUM_MAX
                                                               : lsum_add[26:0];
               end
               if (sx_ext + 11'(margin_ff) >= 11'(rbase_ff) &&
                   sx_ext < 11'(rbase_ff) + 11'(margin_ff)) begin
                  if (rcnt_ff != sws_pkg::CNT_MAX) rcnt_in = rcnt_ff + 1'b1;
                  rsum_in = (rsum_add > 28'(sws_pkg::SUM_MAX)) ? sws_pkg::SUM_MAX
                                                               : rsum_add[26:0];
               end
            end
         end
         sws_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = band_ff;
               rsp_lc_in    = lbase_ff;
               rsp_rc_in    = rbase_ff;
               rsp_lcnt_in  = lcnt_ff;
               rsp_rcnt_in  = rcnt_ff;
               rsp_last_in  = (band_ff == 5'(WINDOWS - 1));
               state_in     = sws_pkg::ST_LDIV;
            end
         end
         sws_pkg::ST_LDIV: begin
            if (lcnt_ff > 17'(minpix_ff)) begin
               div_req.start = 1'b1;
               div_req.num   = lsum_ff;
               div_req.den   = lcnt_ff;
               state_in      = sws_pkg::ST_LWAIT;
            end else begin
               state_in = sws_pkg::ST_RDIV;
            end
         end
         sws_pkg::ST_LWAIT: begin
            if (div_rsp.done) begin
               lbase_in = quot_sat;
               state_in = sws_pkg::ST_RDIV;
            end
         end
         sws_pkg::ST_RDIV: begin
            if (rcnt_ff > 17'(minpix_ff)) begin
               div_req.start = 1'b1;
               div_req.num   = rsum_ff;
               div_req.den   = rcnt_ff;
               state_in      = sws_pkg::ST_RWAIT;
            end else begin
               state_in = sws_pkg::ST_NEXT;
            end
         end
         sws_pkg::ST_RWAIT: begin
            if (div_rsp.done) begin
               rbase_in = quot_sat;
               state_in = sws_pkg::ST_NEXT;
            end
         end
         sws_pkg::ST_NEXT: begin
            if (band_ff == 5'(WINDOWS - 1)) begin
               total_in = '0;
               state_in = sws_pkg::ST_IDLE;
            end else begin
               band_in  = band_ff + 1'b1;
               yhi_in   = ylo_ff;
               state_in = sws_pkg::ST_BAND;
            end
         end
         default: begin
            state_in = sws_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sws_pkg::ST_CLEAR;
         col_ff       <= '0;
         pv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lany_ff      <= 1'b0;
         rany_ff      <= 1'b0;
         band_ff      <= '0;
         lbase_ff     <= '0;
         rbase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         pv_ff        <= pv_in;
         sv_ff        <= sv_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         lany_ff      <= lany_in;
         rany_ff      <= rany_in;
         band_ff      <= band_in;
         lbase_ff     <= lbase_in;
         rbase_ff     <= rbase_in;
      end
      pcol_ff      <= pcol_in;
      lbest_ff     <= lbest_in;
      rbest_ff     <= rbest_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      pend_ff      <= pend_in;
      idx_ff       <= idx_in;
      ylo_ff       <= ylo_in;
      yhi_ff       <= yhi_in;
      prod_ff      <= prod_in;
      lcnt_ff      <= lcnt_in;
      rcnt_ff      <= rcnt_in;
      lsum_ff      <= lsum_in;
      rsum_ff      <= rsum_in;
      rsp_index_ff <= rsp_index_in;
      rsp_lc_ff    <= rsp_lc_in;
      rsp_rc_ff    <= rsp_rc_in;
      rsp_lcnt_ff  <= rsp_lcnt_in;
      rsp_rcnt_ff  <= rsp_rcnt_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= sws_pkg::ROWS_RESET;
         cols_cfg_ff <= sws_pkg::COLS_RESET;
         margin_ff   <= sws_pkg::MARGIN_RESET;
         minpix_ff   <= sws_pkg::MINPIX_RESET;
         lss_ff      <= sws_pkg::LSS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sws_pkg::REG_IMAGE_ROWS:    rows_cfg_ff <= csr_data[10:0];
            sws_pkg::REG_IMAGE_COLS:    cols_cfg_ff <= csr_data[10:0];
            sws_pkg::REG_SEARCH_MARGIN: margin_ff   <= csr_data[7:0];
            sws_pkg::REG_MIN_PIXELS:    minpix_ff   <= csr_data;
            sws_pkg::REG_LEFT_START:    lss_ff      <= csr_data[8:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_index = rsp_index_ff;
   assign rsp_left_center  = rsp_lc_ff;
   assign rsp_right_center = rsp_rc_ff;
   assign rsp_left_count   = rsp_lcnt_ff;
   assign rsp_right_count  = rsp_rcnt_ff;
   assign rsp_last_window  = rsp_last_ff;

endmodule

/* rtl/sws_ram.sv */
// ----------------------------------------------------------------------------
// sws_ram
// Simple dual-port memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sws_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 17
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read and a write to the same entry in one cycle return the old value.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/sws_div.sv */
// ----------------------------------------------------------------------------
// sws_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module sws_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sws_pkg::div_req_type req,
   output sws_pkg::div_rsp_type rsp
);

   localparam int NW = sws_pkg::DIV_NUM_W;
   localparam int DW = sws_pkg::DIV_DEN_W;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sws_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]                  rem_ff, rem_in;
   logic [DW-1:0]                  den_ff, den_in;
   logic [NW-1:0]                  qn_ff, qn_in;
   logic [DW:0]                    trial;
   logic                           ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      qn_in   = qn_ff;
      trial   = {rem_ff, qn_ff[NW-1]};
      ge      = trial >= {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = req.den;
         qn_in   = req.num;
      end else if (busy_ff) begin
         // The numerator shifts out at the top while quotient bits enter below.
         rem_in = ge ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         qn_in  = {qn_ff[NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sws_pkg::DIV_CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      qn_ff  <= qn_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = qn_ff;

endmodule

/* dv/tb_sliding_window_lane_search_top.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_lane_search_top
// Streams frames of lane pixels into the search block under several register
// settings and random flow control, and checks every band summary against a
// scoreboard that tracks the pixel store, histogram and window centers.
// ----------------------------------------------------------------------------
typedef struct packed {
   bit [4:0]  index;
   bit [9:0]  lcenter;
   bit [9:0]  rcenter;
   bit [16:0] lcount;
   bit [16:0] rcount;
   bit        last;
} band_summary_type;

class lane_search_scoreboard;
   int unsigned      rows_reg, cols_reg, margin_reg, minpix_reg, lstart_reg;
   bit [19:0]        stored_pixels[$];
   int unsigned      col_hist[1024];
   band_summary_type band_queue[$];
   int               errors;

   function new();
      rows_reg   = 720;
      cols_reg   = 1024;
      margin_reg = 60;
      minpix_reg = 50;
      lstart_reg = 50;
      errors     = 0;
      foreach (col_hist[i]) col_hist[i] = 0;
   endfunction

   function void write_reg(bit [2:0] index, bit [15:0] data);
      case (index)
         sws_pkg::REG_IMAGE_ROWS:    rows_reg   = int'(data[10:0]);
         sws_pkg::REG_IMAGE_COLS:    cols_reg   = int'(data[10:0]);
         sws_pkg::REG_SEARCH_MARGIN: margin_reg = int'(data[7:0]);
         sws_pkg::REG_MIN_PIXELS:    minpix_reg = int'(data[15:0]);
         sws_pkg::REG_LEFT_START:    lstart_reg = int'(data[8:0]);
         default: ;
      endcase
   endfunction

   function int pending();
      return band_queue.size();
   endfunction

   function int unsigned first_peak(int unsigned lo, int unsigned hi);
      int unsigned best, bestv;
      best  = lo;
      bestv = 0;
      for (int unsigned i = lo; i < hi && i < 1024; i++) begin
         if (i == lo || col_hist[i] > bestv) begin
            bestv = col_hist[i];
            best  = i;
         end
      end
      return best;
   endfunction

   function void note_pixel(bit [9:0] x, bit [9:0] y, bit frame_end);
      int unsigned      rows, cols, half, mid, hi, lbase, rbase, lcnt, rcnt, lsum, rsum;
      int               ylo, yhi, px, py, mg;
      band_summary_type s;
      rows = (rows_reg < 1) ? 1 : (rows_reg > 1024) ? 1024 : rows_reg;
      cols = (cols_reg > 1024) ? 1024 : (cols_reg < 2) ? 2 : cols_reg;
      half = rows / 2;
      mid  = cols / 2;
      if (x < cols && y < rows) begin
         if (stored_pixels.size() < 65536)
            stored_pixels.insert(stored_pixels.size(), {y, x});
         if (y >= half && y < 2 * half && col_hist[x] < 17'h1FFFF) col_hist[x]++;
      end
      if (!frame_end) return;
      hi = lstart_reg + mid;
      if (hi > cols) hi = cols;
      lbase = (lstart_reg < hi) ? first_peak(lstart_reg, hi) : lstart_reg;
      rbase = first_peak(mid, 2 * mid);
      mg = int'(margin_reg);
      for (int w = 0; w < sws_pkg::WINDOWS_DEF; w++) begin
         ylo  = int'(rows * (sws_pkg::WINDOWS_DEF - w - 1) / sws_pkg::WINDOWS_DEF);
         yhi  = int'(rows * (sws_pkg::WINDOWS_DEF - w) / sws_pkg::WINDOWS_DEF);
         lcnt = 0; rcnt = 0; lsum = 0; rsum = 0;
         foreach (stored_pixels[i]) begin
            px = int'(stored_pixels[i][9:0]);
            py = int'(stored_pixels[i][19:10]);
            if (py < ylo || py >= yhi) continue;
            if (px >= int'(lbase) - mg && px < int'(lbase) + mg) begin
               if (lcnt < 17'h1FFFF) lcnt++;
               lsum = (lsum > 27'h7FFFFFF - px) ? 27'h7FFFFFF : lsum + px;
            end
            if (px >= int'(rbase) - mg && px < int'(rbase) + mg) begin
               if (rcnt < 17'h1FFFF) rcnt++;
               rsum = (rsum > 27'h7FFFFFF - px) ? 27'h7FFFFFF : rsum + px;
            end
         end
         s.index   = 5'(w);
         s.lcenter = 10'(lbase);
         s.rcenter = 10'(rbase);
         s.lcount  = 17'(lcnt);
         s.rcount  = 17'(rcnt);
         s.last    = (w == sws_pkg::WINDOWS_DEF - 1);
         band_queue.insert(band_queue.size(), s);
         if (lcnt > minpix_reg) lbase = (lsum / lcnt > 1023) ? 1023 : lsum / lcnt;
         if (rcnt > minpix_reg) rbase = (rsum / rcnt > 1023) ? 1023 : rsum / rcnt;
      end
      stored_pixels.delete();
      foreach (col_hist[i]) col_hist[i] = 0;
   endfunction

   function void check_result(band_summary_type got);
      band_summary_type exp_s;
      if (band_queue.size() == 0) begin
         $display("%0t: unexpected band summary, window %0d", $realtime, got.index);
         errors++;
         return;
      end
      exp_s = band_queue.pop_front();
      if (got != exp_s) begin
         $display("%0t: mismatch exp idx=%0d lc=%0d rc=%0d ln=%0d rn=%0d last=%0d",
                  $realtime, exp_s.index, exp_s.lcenter, exp_s.rcenter,
                  exp_s.lcount, exp_s.rcount, exp_s.last);
         $display("%0t:          act idx=%0d lc=%0d rc=%0d ln=%0d rn=%0d last=%0d",
                  $realtime, got.index, got.lcenter, got.rcenter,
                  got.lcount, got.rcount, got.last);
         errors++;
      end
   endfunction
endclass

module tb_sliding_window_lane_search_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [9:0]  req_pixel_x = '0;
   logic [9:0]  req_pixel_y = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_window_index;
   logic [9:0]  rsp_left_center;
   logic [9:0]  rsp_right_center;
   logic [16:0] rsp_left_count;
   logic [16:0] rsp_right_count;
   logic        rsp_last_window;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   lane_search_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;
   int hold_req      = 0;
   int hold_ack      = 0;

   sliding_window_lane_search_top DUT (.*);

   always #6 clock = ~clock;

   // Receiver: a long hold-off, when requested, overrides random idling.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (hold_req != hold_ack) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= 3000;
         hold_ack    <= hold_req;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      band_summary_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.index   = rsp_window_index;
         got.lcenter = rsp_left_center;
         got.rcenter = rsp_right_center;
         got.lcount  = rsp_left_count;
         got.rcount  = rsp_right_count;
         got.last    = rsp_last_window;
         sb.check_result(got);
      end
   end

   task automatic send_pixel(bit [9:0] x, bit [9:0] y, bit frame_end);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pixel_x   <= x;
      req_pixel_y   <= y;
      req_frame_end <= frame_end;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(x, y, frame_end);
   endtask

   task automatic write_csr(bit [2:0] index, bit [15:0] data);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
      csr_valid <= 1'b0;
   endtask

   // After the last beat the block still finishes its recentre divides.
   task automatic drain_bands();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_regs(bit [15:0] rows, bit [15:0] cols, bit [15:0] margin,
                           bit [15:0] minpix, bit [15:0] lstart);
      drain_bands();
      write_csr(sws_pkg::REG_IMAGE_ROWS, rows);
      write_csr(sws_pkg::REG_IMAGE_COLS, cols);
      write_csr(sws_pkg::REG_SEARCH_MARGIN, margin);
      write_csr(sws_pkg::REG_MIN_PIXELS, minpix);
      write_csr(sws_pkg::REG_LEFT_START, lstart);
   endtask

   // Pixels cluster around two lanes so that windows recenter; some are noise.
   task automatic lane_frame(int npix);
      int cols, rows, lx, rx, x, y;
      cols = (sb.cols_reg > 1024) ? 1024 : (sb.cols_reg < 2) ? 2 : sb.cols_reg;
      rows = (sb.rows_reg > 1024) ? 1024 : (sb.rows_reg < 1) ? 1 : sb.rows_reg;
      lx = $urandom_range(cols / 2);
      rx = $urandom_range(cols - 1, cols / 2);
      for (int i = 0; i < npix; i++) begin
         if ($urandom_range(9) == 0) begin
            x = $urandom_range(1023);
            y = $urandom_range(1023);
         end else begin
            x = ((i % 2) ? rx : lx) + int'($urandom_range(16)) - 8;
            if (x < 0) x = 0;
            if (x > cols - 1) x = cols - 1;
            y = $urandom_range(rows - 1);
         end
         send_pixel(10'(x), 10'(y), i == npix - 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, corners, out-of-frame pixels, empty frame.
      send_pixel(10'd0, 10'd0, 1'b0);
      send_pixel(10'd1023, 10'd719, 1'b0);
      send_pixel(10'd1023, 10'd1023, 1'b0);
      send_pixel(10'd60, 10'd700, 1'b0);
      send_pixel(10'd61, 10'd700, 1'b0);
      send_pixel(10'd600, 10'd400, 1'b1);
      send_pixel(10'd1023, 10'd1023, 1'b1);
      set_regs(16'd1, 16'd2, 16'd0, 16'd0, 16'd0);
      send_pixel(10'd0, 10'd0, 1'b0);
      send_pixel(10'd1, 10'd0, 1'b0);
      send_pixel(10'd2, 10'd0, 1'b1);
      set_regs(16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF, 16'h01FF);
      send_pixel(10'd511, 10'd1023, 1'b0);
      send_pixel(10'd512, 10'd512, 1'b0);
      send_pixel(10'd300, 10'd600, 1'b1);
      set_regs(16'd0, 16'd0, 16'd3, 16'd0, 16'd0);
      send_pixel(10'd0, 10'd0, 1'b0);
      send_pixel(10'd1, 10'd0, 1'b1);
      set_regs(16'd1024, 16'd1024, 16'd40, 16'd1, 16'd500);
      send_pixel(10'd1000, 10'd900, 1'b0);
      send_pixel(10'd1010, 10'd900, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 6 : 0;
         set_regs(16'($urandom_range(1024, 1)), 16'($urandom_range(1024, 2)),
                  16'($urandom_range(255)), 16'($urandom_range(3)),
                  16'($urandom_range(511)));
         if (phase == 2) hold_req <= hold_req + 1;
         for (int f = 0; f < 6; f++) lane_frame($urandom_range(15, 1));
      end
      set_regs(16'd720, 16'd1024, 16'd60, 16'd50, 16'd50);
      lane_frame(12);

      drain_bands();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("tb: failure");
      $finish;
   end
endmodule
